// ===== hdl/sfd_pkg.sv =====
// Shared constants, widths and a helper function for the smoothed first-derivative core.
`default_nettype none

package sfd_pkg;

  // Sizing of the record store and of the smoothing window.
  localparam int unsigned MAX_ORDER    = 15;
  localparam int unsigned WINDOW_DEPTH = 32;
  localparam int unsigned MAX_LENGTH   = 4096;

  // Field widths of the ports.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned IDX_OUT_W = 12;
  localparam int unsigned DER_W     = 32;
  localparam int unsigned INV_W     = 24;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned ORDER_W   = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 24;

  // The usable half width is bounded by the order limit and by the window size.
  localparam int unsigned ORDER_CAP =
      (MAX_ORDER < (WINDOW_DEPTH - 1) / 2) ? MAX_ORDER : (WINDOW_DEPTH - 1) / 2;

  // Derived widths.
  localparam int unsigned CNT_W  = $clog2(MAX_LENGTH + 1);
  localparam int unsigned LEN_W  = $clog2(MAX_LENGTH);
  localparam int unsigned WIN_AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned IDX_W  = CNT_W + 1;
  localparam int unsigned DIFF_W = SAMPLE_W + 1;
  localparam int unsigned PART_W = DIFF_W + $clog2(ORDER_CAP + 1);
  localparam int unsigned TOT_W  = PART_W + $clog2(ORDER_CAP + 1);
  localparam int unsigned PROD_W = TOT_W + INV_W;
  localparam int unsigned STEP_W = $clog2(PROD_W);

  // Divisors: one-sided, central, five-point, and the largest window divisor.
  localparam int unsigned MAX_DIVISOR = ORDER_CAP * (ORDER_CAP + 1) * (2 * ORDER_CAP + 1) / 3;
  localparam int unsigned DIV_W = $clog2(((MAX_DIVISOR > 10) ? MAX_DIVISOR : 10) + 1);
  localparam logic [DIV_W-1:0] DIV_ONE_SIDED  = DIV_W'(1);
  localparam logic [DIV_W-1:0] DIV_CENTRAL    = DIV_W'(2);
  localparam logic [DIV_W-1:0] DIV_FIVE_POINT = DIV_W'(10);

  // Saturation bounds of the derivative.
  localparam logic signed [DER_W-1:0] DER_MAX = {1'b0, {(DER_W - 1){1'b1}}};
  localparam logic signed [DER_W-1:0] DER_MIN = {1'b1, {(DER_W - 1){1'b0}}};
  localparam logic [PROD_W-1:0] SAT_NEG = PROD_W'(1) << (DER_W - 1);
  localparam logic [PROD_W-1:0] SAT_POS = SAT_NEG - PROD_W'(1);

  // Status codes carried on the final result.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LONG  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [ORDER_W-1:0]      ORDER_RST = 4'd2;
  localparam logic signed [INV_W-1:0] INV_RST   = 24'sd65536;
  localparam logic [LIMIT_W-1:0]      LIMIT_RST = 16'd32768;

  // Window divisor for half width n: n(n+1)(2n+1)/3, built as twice the sum of squares.
  function automatic logic [DIV_W-1:0] sfd_divisor(input logic [ORDER_W-1:0] n);
    logic [DIV_W-1:0] s;
    s = '0;
    for (int i = 1; i <= ORDER_CAP; i++) begin
      if (i <= int'(n)) begin
        s = s + DIV_W'(2 * i * i);
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sfd_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module sfd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_a_i,
  output logic [WIDTH-1:0]          rdata_a_o,
  input  wire [$clog2(DEPTH)-1:0]   raddr_b_i,
  output logic [WIDTH-1:0]          rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== hdl/smoothed_first_derivative_core.sv =====
// Smoothed first derivative of a streamed record, on one shared accumulate and divide unit.
// Each point passes the states setup, read and accumulate for every window tap, multiply,
// normalise, a serial restoring divide, saturate and output, in that order.
// Samples are taken one at a time, only while the sequencer is idle; an end-of-record sample
// releases up to effective order + 1 points, and a stalled output register holds the sequencer.
// Reset: order 2, unit step and range limit 32768; the record is cleared but the window is not.
`default_nettype none

module smoothed_first_derivative_core (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire signed [sfd_pkg::SAMPLE_W-1:0]      sample_i,
  input  wire                                     end_of_record_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic [sfd_pkg::IDX_OUT_W-1:0]           point_index_o,
  output logic signed [sfd_pkg::DER_W-1:0]        derivative_o,
  output logic                                    final_res_o,
  output logic signed [sfd_pkg::DER_W-1:0]        peak_derivative_o,
  output logic [sfd_pkg::STATUS_W-1:0]            status_o,
  input  wire                                     cfg_we_i,
  input  wire [sfd_pkg::CFG_IDX_W-1:0]            cfg_index_i,
  input  wire [sfd_pkg::CFG_W-1:0]                cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_READ, S_ACC, S_MUL, S_NORM, S_DIV, S_SAT, S_OUT
  } state_e;

  // Working registers of the point sequencer.
  typedef struct packed {
    logic [sfd_pkg::ORDER_W-1:0]       n;
    logic [sfd_pkg::DIV_W-1:0]         mid_div;
    logic [sfd_pkg::LEN_W-1:0]         last;
    logic                              eor;
    logic                              endk;
    logic [sfd_pkg::LEN_W-1:0]         pt;
    logic signed [sfd_pkg::IDX_W-1:0]  ch;
    logic signed [sfd_pkg::IDX_W-1:0]  cl;
    logic [sfd_pkg::ORDER_W-1:0]       j;
    logic [sfd_pkg::DIV_W-1:0]         dv;
    logic                              hi_ok;
    logic                              lo_ok;
    logic signed [sfd_pkg::PART_W-1:0] part;
    logic signed [sfd_pkg::TOT_W-1:0]  tot;
    logic signed [sfd_pkg::PROD_W-1:0] prod;
    logic [sfd_pkg::PROD_W-1:0]        quo;
    logic [sfd_pkg::DIV_W-1:0]         rem;
    logic                              neg;
    logic [sfd_pkg::STEP_W-1:0]        step;
    logic signed [sfd_pkg::DER_W-1:0]  val;
    logic                              fin;
  } work_t;

  // Output register contents.
  typedef struct packed {
    logic                              valid;
    logic [sfd_pkg::IDX_OUT_W-1:0]     idx;
    logic signed [sfd_pkg::DER_W-1:0]  der;
    logic                              fin;
    logic signed [sfd_pkg::DER_W-1:0]  peak;
    logic [sfd_pkg::STATUS_W-1:0]      status;
  } res_t;

  state_e state_q, state_d;
  work_t  w_q, w_d;
  res_t   res_q, res_d;
  logic [sfd_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [sfd_pkg::DER_W-1:0] peak_q, peak_d;
  logic [sfd_pkg::STATUS_W-1:0]     err_q, err_d;

  logic [sfd_pkg::ORDER_W-1:0]      order_q;
  logic signed [sfd_pkg::INV_W-1:0] inv_q;
  logic [sfd_pkg::LIMIT_W-1:0]      limit_q;

  logic                             in_acc;
  logic                             ram_we;
  logic [sfd_pkg::WIN_AW-1:0]       raddr_a, raddr_b;
  logic [sfd_pkg::SAMPLE_W-1:0]     rdata_a, rdata_b;

  logic [sfd_pkg::ORDER_W-1:0]       eff_n;
  logic [sfd_pkg::SAMPLE_W:0]        sx, mag_x;
  logic signed [sfd_pkg::IDX_W-1:0]  k_s, last_s, size_s, n_s, j_s, hi_s, lo_s, start_s;
  logic                              edge_hi, edge_lo, central;
  logic signed [sfd_pkg::SAMPLE_W-1:0] dat_hi, dat_lo;
  logic signed [sfd_pkg::DIFF_W-1:0] diff;
  logic signed [sfd_pkg::PART_W-1:0] part_n;
  logic signed [sfd_pkg::TOT_W-1:0]  tot_n;
  logic [sfd_pkg::PROD_W-1:0]        mag_p;
  logic [sfd_pkg::DIV_W:0]           rem_sh, rem_sub;
  logic signed [sfd_pkg::DER_W-1:0]  val_n;
  logic [sfd_pkg::STATUS_W-1:0]      status_c;

  // Sample window store.
  sfd_ram #(
    .WIDTH (sfd_pkg::SAMPLE_W),
    .DEPTH (sfd_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (cnt_q[sfd_pkg::WIN_AW-1:0]),
    .wdata_i   (sample_i),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // Handshake: samples are taken only while the sequencer is idle.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Effective order: zero acts as one, and the order is capped by the window.
  assign eff_n = (order_q == '0) ? sfd_pkg::ORDER_W'(1) :
                 (order_q > sfd_pkg::ORDER_W'(sfd_pkg::ORDER_CAP)) ?
                 sfd_pkg::ORDER_W'(sfd_pkg::ORDER_CAP) : order_q;

  // Magnitude of the incoming sample for the range check.
  assign sx    = {sample_i[sfd_pkg::SAMPLE_W-1], sample_i};
  assign mag_x = sx[sfd_pkg::SAMPLE_W] ? (~sx + 1'b1) : sx;

  // Signed views of the point position and record geometry.
  assign k_s     = sfd_pkg::IDX_W'(w_q.pt);
  assign last_s  = sfd_pkg::IDX_W'(w_q.last);
  assign size_s  = last_s + sfd_pkg::IDX_W'(1);
  assign n_s     = sfd_pkg::IDX_W'(w_q.n);
  assign j_s     = sfd_pkg::IDX_W'(w_q.j);
  assign start_s = size_s - n_s;

  // Point classification near the record edges.
  assign edge_hi = w_q.endk && (k_s >= start_s);
  assign edge_lo = (k_s >= 1) && (k_s < n_s);
  assign central = edge_hi ? (k_s == size_s - 2) : (k_s == 1);

  // Window addresses of the sample pair of the current step.
  assign hi_s    = w_q.ch + j_s;
  assign lo_s    = w_q.cl - j_s;
  assign raddr_a = hi_s[sfd_pkg::WIN_AW-1:0];
  assign raddr_b = lo_s[sfd_pkg::WIN_AW-1:0];

  // Accumulation: the running partial sum weights step j by j as j counts down.
  assign dat_hi = w_q.hi_ok ? rdata_a : '0;
  assign dat_lo = w_q.lo_ok ? rdata_b : '0;
  assign diff   = sfd_pkg::DIFF_W'(dat_hi) - sfd_pkg::DIFF_W'(dat_lo);
  assign part_n = w_q.part + sfd_pkg::PART_W'(diff);
  assign tot_n  = w_q.tot + sfd_pkg::TOT_W'(part_n);

  // Magnitude of the scaled sum, and one restoring divide step.
  assign mag_p   = w_q.prod[sfd_pkg::PROD_W-1] ? sfd_pkg::PROD_W'(-w_q.prod) :
                                                 sfd_pkg::PROD_W'(w_q.prod);
  assign rem_sh  = {w_q.rem, w_q.quo[sfd_pkg::PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, w_q.dv};

  // Sign and saturation of the rounded quotient.
  always_comb begin
    if (w_q.neg) begin
      val_n = (w_q.quo > sfd_pkg::SAT_NEG) ? sfd_pkg::DER_MIN :
              sfd_pkg::DER_W'(~w_q.quo[sfd_pkg::DER_W-1:0] + 1'b1);
    end else begin
      val_n = (w_q.quo > sfd_pkg::SAT_POS) ? sfd_pkg::DER_MAX :
              w_q.quo[sfd_pkg::DER_W-1:0];
    end
  end

  // Status of the final result.
  assign status_c = (err_q != sfd_pkg::ST_OK) ? err_q :
                    ((size_s < 2 * n_s) || (size_s < 4)) ? sfd_pkg::ST_SHORT : sfd_pkg::ST_OK;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    cnt_d   = cnt_q;
    peak_d  = peak_q;
    err_d   = err_q;
    ram_we  = 1'b0;

    // The output register empties on a transfer.
    res_d = res_q;
    if (res_q.valid && !out_stall_i) begin
      res_d.valid = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_q >= sfd_pkg::CNT_W'(sfd_pkg::MAX_LENGTH)) begin
            // Record too long: the sample is dropped.
            err_d = sfd_pkg::ST_LONG;
            if (end_of_record_i) begin
              w_d.pt   = '0;
              w_d.val  = '0;
              w_d.fin  = 1'b1;
              w_d.endk = 1'b1;
              state_d  = S_OUT;
            end
          end else begin
            ram_we = 1'b1;
            if (err_q == sfd_pkg::ST_OK && mag_x >= {1'b0, limit_q}) begin
              err_d = sfd_pkg::ST_RANGE;
            end
            cnt_d       = cnt_q + 1'b1;
            w_d.n       = eff_n;
            w_d.mid_div = sfd_pkg::sfd_divisor(eff_n);
            w_d.last    = cnt_q[sfd_pkg::LEN_W-1:0];
            w_d.eor     = end_of_record_i;
            w_d.fin     = 1'b0;
            if (cnt_q >= sfd_pkg::CNT_W'(eff_n)) begin
              w_d.pt   = cnt_q[sfd_pkg::LEN_W-1:0] - sfd_pkg::LEN_W'(eff_n);
              w_d.endk = 1'b0;
              state_d  = S_SETUP;
            end else if (end_of_record_i) begin
              w_d.pt   = '0;
              w_d.endk = 1'b1;
              state_d  = S_SETUP;
            end
          end
        end
      end

      S_SETUP: begin
        // Choose the difference formula and its divisor for this point.
        w_d.part = '0;
        w_d.tot  = '0;
        if (w_q.endk && w_q.pt == w_q.last) begin
          w_d.ch = last_s - sfd_pkg::IDX_W'(1);
          w_d.cl = last_s;
          w_d.j  = sfd_pkg::ORDER_W'(1);
          w_d.dv = sfd_pkg::DIV_ONE_SIDED;
        end else if (edge_hi || edge_lo) begin
          w_d.ch = k_s;
          w_d.cl = k_s;
          w_d.j  = central ? sfd_pkg::ORDER_W'(1) : sfd_pkg::ORDER_W'(2);
          w_d.dv = central ? sfd_pkg::DIV_CENTRAL : sfd_pkg::DIV_FIVE_POINT;
        end else if (w_q.pt == '0) begin
          w_d.ch = '0;
          w_d.cl = sfd_pkg::IDX_W'(1);
          w_d.j  = sfd_pkg::ORDER_W'(1);
          w_d.dv = sfd_pkg::DIV_ONE_SIDED;
        end else begin
          w_d.ch = k_s;
          w_d.cl = k_s;
          w_d.j  = w_q.n;
          w_d.dv = w_q.mid_div;
        end
        state_d = S_READ;
      end

      S_READ: begin
        // Samples outside the record read as zero.
        w_d.hi_ok = (hi_s >= 0) && (hi_s <= last_s);
        w_d.lo_ok = (lo_s >= 0) && (lo_s <= last_s);
        state_d   = S_ACC;
      end

      S_ACC: begin
        w_d.part = part_n;
        w_d.tot  = tot_n;
        if (w_q.j == sfd_pkg::ORDER_W'(1)) begin
          state_d = S_MUL;
        end else begin
          w_d.j   = w_q.j - 1'b1;
          state_d = S_READ;
        end
      end

      S_MUL: begin
        w_d.prod = sfd_pkg::PROD_W'(w_q.tot) * sfd_pkg::PROD_W'(inv_q);
        state_d  = S_NORM;
      end

      S_NORM: begin
        // Round to nearest, ties away from zero, by adding half the divisor to the magnitude.
        w_d.quo  = mag_p + sfd_pkg::PROD_W'(w_q.dv >> 1);
        w_d.neg  = w_q.prod[sfd_pkg::PROD_W-1];
        w_d.rem  = '0;
        w_d.step = '0;
        state_d  = S_DIV;
      end

      S_DIV: begin
        if (rem_sh >= {1'b0, w_q.dv}) begin
          w_d.rem = rem_sub[sfd_pkg::DIV_W-1:0];
          w_d.quo = {w_q.quo[sfd_pkg::PROD_W-2:0], 1'b1};
        end else begin
          w_d.rem = rem_sh[sfd_pkg::DIV_W-1:0];
          w_d.quo = {w_q.quo[sfd_pkg::PROD_W-2:0], 1'b0};
        end
        w_d.step = w_q.step + 1'b1;
        if (w_q.step == sfd_pkg::STEP_W'(sfd_pkg::PROD_W - 1)) begin
          state_d = S_SAT;
        end
      end

      S_SAT: begin
        w_d.val = val_n;
        w_d.fin = w_q.endk && (w_q.pt == w_q.last);
        if (k_s >= 1 && (!w_q.eor || k_s + 3 <= size_s) && val_n > peak_q) begin
          peak_d = val_n;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        // Load the output register once it is free or being emptied.
        if (!res_q.valid || !out_stall_i) begin
          res_d.valid  = 1'b1;
          res_d.idx    = sfd_pkg::IDX_OUT_W'(w_q.pt);
          res_d.der    = w_q.val;
          res_d.fin    = w_q.fin;
          res_d.peak   = w_q.fin ? peak_q : '0;
          res_d.status = w_q.fin ? status_c : sfd_pkg::ST_OK;
          if (w_q.fin) begin
            cnt_d   = '0;
            peak_d  = sfd_pkg::DER_MIN;
            err_d   = sfd_pkg::ST_OK;
            state_d = S_IDLE;
          end else if (!w_q.endk) begin
            if (w_q.eor) begin
              w_d.pt   = (start_s > 0) ? start_s[sfd_pkg::LEN_W-1:0] : '0;
              w_d.endk = 1'b1;
              state_d  = S_SETUP;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            w_d.pt  = w_q.pt + 1'b1;
            state_d = S_SETUP;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, working registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      w_q     <= '0;
      res_q   <= '0;
      cnt_q   <= '0;
      peak_q  <= sfd_pkg::DER_MIN;
      err_q   <= sfd_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      res_q   <= res_d;
      cnt_q   <= cnt_d;
      peak_q  <= peak_d;
      err_q   <= err_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= sfd_pkg::ORDER_RST;
      inv_q   <= sfd_pkg::INV_RST;
      limit_q <= sfd_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfd_pkg::REG_ORDER: order_q <= cfg_data_i[sfd_pkg::ORDER_W-1:0];
        sfd_pkg::REG_INV:   inv_q   <= cfg_data_i[sfd_pkg::INV_W-1:0];
        sfd_pkg::REG_LIMIT: limit_q <= cfg_data_i[sfd_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result ports.
  assign out_valid_o       = res_q.valid;
  assign point_index_o     = res_q.idx;
  assign derivative_o      = res_q.der;
  assign final_res_o       = res_q.fin;
  assign peak_derivative_o = res_q.peak;
  assign status_o          = res_q.status;

endmodule

`default_nettype wire

// ===== sim/sfd_slope_checker.sv =====
// Checker for the smoothed first-derivative core: predicts every point from the accepted samples.
`timescale 1ns / 100ps

module sfd_slope_checker
  import sfd_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire [CFG_W-1:0]            cfg_data_i,
  input  wire                        in_valid_i,
  input  wire                        in_stall_i,
  input  wire signed [SAMPLE_W-1:0]  sample_i,
  input  wire                        end_of_record_i,
  input  wire                        out_valid_i,
  input  wire                        out_stall_i,
  input  wire [IDX_OUT_W-1:0]        point_index_i,
  input  wire signed [DER_W-1:0]     derivative_i,
  input  wire                        final_res_i,
  input  wire signed [DER_W-1:0]     peak_derivative_i,
  input  wire [STATUS_W-1:0]         status_i,
  output int                         mismatch_count_o,
  output int                         outstanding_o
);

  typedef struct {
    logic [IDX_OUT_W-1:0]    idx;
    logic signed [DER_W-1:0] slope;
    logic                    fin;
    logic signed [DER_W-1:0] peak;
    logic [STATUS_W-1:0]     code;
  } point_t;

  // Own copy of the record state and of the registers.
  logic signed [SAMPLE_W-1:0] window_mem [WINDOW_DEPTH];
  int                         held_count;
  logic signed [DER_W-1:0]    peak_so_far;
  logic [STATUS_W-1:0]        record_error;
  logic [ORDER_W-1:0]         order_reg;
  logic signed [INV_W-1:0]    inv_reg;
  logic [LIMIT_W-1:0]         limit_reg;

  // Points still owed by the core, oldest first.
  point_t pending_points[$];

  // The half width actually used: zero acts as one, and the window bounds it.
  function automatic int order_in_use();
    int n;
    n = int'(order_reg);
    if (n < 1) n = 1;
    if (n > int'(MAX_ORDER)) n = int'(MAX_ORDER);
    if (n > (int'(WINDOW_DEPTH) - 1) / 2) n = (int'(WINDOW_DEPTH) - 1) / 2;
    return n;
  endfunction

  // Samples outside the current record read as zero.
  function automatic longint held(int pos, int last);
    if (pos < 0 || pos > last) return 0;
    return longint'(window_mem[pos % int'(WINDOW_DEPTH)]);
  endfunction

  // Exact num * inv_step * mul / div, rounded half away from zero, saturated to Q16.16.
  function automatic logic signed [DER_W-1:0] scale_q16(longint num, longint mul, longint div);
    longint prod;
    longint mag;
    longint quo;
    prod = num * longint'(inv_reg) * mul;
    mag  = (prod < 0) ? -prod : prod;
    quo  = (mag + div / 2) / div;
    if (prod < 0) begin
      if (quo > 64'sd2147483648) return DER_MIN;
      return DER_W'(-quo);
    end
    if (quo > 64'sd2147483647) return DER_MAX;
    return DER_W'(quo);
  endfunction

  // Derivative of point k; the record end is only known on the end-of-record sample.
  function automatic logic signed [DER_W-1:0] slope_at(int k, int last, int n, bit end_known);
    int     size;
    int     j;
    bit     central;
    longint acc;
    size = last + 1;
    if (end_known && k == last) begin
      return scale_q16(held(last, last) - held(last - 1, last), 1, 1);
    end
    if ((end_known && k >= size - n) || (k >= 1 && k < n)) begin
      central = (end_known && k >= size - n) ? (k == size - 2) : (k == 1);
      if (central) begin
        return scale_q16(held(k + 1, last) - held(k - 1, last), 1, 2);
      end
      return scale_q16(2 * (held(k + 2, last) - held(k - 2, last))
                       + held(k + 1, last) - held(k - 1, last), 1, 10);
    end
    if (k == 0) begin
      return scale_q16(held(1, last) - held(0, last), 1, 1);
    end
    acc = 0;
    for (j = 1; j <= n; j++) begin
      acc += j * (held(k + j, last) - held(k - j, last));
    end
    return scale_q16(acc, 3, longint'(n) * (n + 1) * (2 * n + 1));
  endfunction

  function automatic point_t make_point(int pos, logic signed [DER_W-1:0] v, logic fin,
                                        logic signed [DER_W-1:0] pk, logic [STATUS_W-1:0] st);
    point_t pt;
    pt.idx   = IDX_OUT_W'(pos);
    pt.slope = v;
    pt.fin   = fin;
    pt.peak  = pk;
    pt.code  = st;
    return pt;
  endfunction

  task automatic clear_record();
    held_count   = 0;
    peak_so_far  = DER_MIN;
    record_error = ST_OK;
  endtask

  // Works out the points that one accepted sample releases.
  task automatic predict_points(input logic signed [SAMPLE_W-1:0] x, input logic eor);
    int                      n;
    int                      m;
    int                      k;
    int                      size;
    int                      p;
    int                      mag;
    logic signed [DER_W-1:0] v;
    logic [STATUS_W-1:0]     st;
    n = order_in_use();
    // A record past its maximum length drops samples and reports only on its end.
    if (held_count >= int'(MAX_LENGTH)) begin
      record_error = ST_LONG;
      if (eor) begin
        pending_points.push_back(make_point(0, '0, 1'b1, peak_so_far, ST_LONG));
        clear_record();
      end
      return;
    end
    m = held_count;
    window_mem[m % int'(WINDOW_DEPTH)] = x;
    mag = (x < 0) ? -int'(x) : int'(x);
    if (mag >= int'(limit_reg) && record_error == ST_OK) record_error = ST_RANGE;
    held_count++;
    k    = m - n;
    size = m + 1;
    // The point whose right-hand window has just been completed.
    if (k >= 0) begin
      v = slope_at(k, m, n, 1'b0);
      if (k >= 1 && (!eor || k + 3 <= size) && v > peak_so_far) peak_so_far = v;
      pending_points.push_back(make_point(k, v, 1'b0, '0, ST_OK));
    end
    if (!eor) return;
    // Flush the trailing points; the last one carries the peak and the status.
    for (p = (size - n < 0) ? 0 : size - n; p <= m; p++) begin
      v = slope_at(p, m, n, 1'b1);
      if (p >= 1 && p + 3 <= size && v > peak_so_far) peak_so_far = v;
      if (p < m) begin
        pending_points.push_back(make_point(p, v, 1'b0, '0, ST_OK));
      end else begin
        st = record_error;
        if (st == ST_OK && (size < 2 * n || size < 4)) st = ST_SHORT;
        pending_points.push_back(make_point(p, v, 1'b1, peak_so_far, st));
      end
    end
    clear_record();
  endtask

  task automatic note_mismatch(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    mismatch_count_o++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // Handles register writes, then sample transfers, then result transfers, in that order.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t pt;
    if (!rst_ni) begin
      clear_record();
      order_reg = ORDER_RST;
      inv_reg   = INV_RST;
      limit_reg = LIMIT_RST;
      pending_points.delete();
      for (int i = 0; i < int'(WINDOW_DEPTH); i++) window_mem[i] = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ORDER: order_reg = cfg_data_i[ORDER_W-1:0];
          REG_INV:   inv_reg   = cfg_data_i[INV_W-1:0];
          REG_LIMIT: limit_reg = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_points(sample_i, end_of_record_i);
      if (out_valid_i && !out_stall_i) begin
        if (pending_points.size() == 0) begin
          mismatch_count_o++;
          $display("%0t ns: unexpected result, expected none, got point %0d derivative %0d",
                   $time, point_index_i, derivative_i);
        end else begin
          pt = pending_points.pop_front();
          if (point_index_i !== pt.idx) note_mismatch("point_index", pt.idx, point_index_i);
          if (derivative_i !== pt.slope) note_mismatch("derivative", pt.slope, derivative_i);
          if (final_res_i !== pt.fin) note_mismatch("final_res", pt.fin, final_res_i);
          if (peak_derivative_i !== pt.peak) begin
            note_mismatch("peak_derivative", pt.peak, peak_derivative_i);
          end
          if (status_i !== pt.code) note_mismatch("status", pt.code, status_i);
        end
      end
    end
    outstanding_o = pending_points.size();
  end

endmodule

// ===== sim/tb_smoothed_first_derivative_core.sv =====
// Testbench top for the smoothed first-derivative core: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_smoothed_first_derivative_core;
  import sfd_pkg::*;

  localparam int HOLD_CYCLES   = 700;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS   = 35;

  // Directed samples: extremes and bit patterns; record ends are marked below.
  localparam logic signed [SAMPLE_W-1:0] DIRECTED_SAMPLES [25] = '{
    16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh8000,
    16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA, 16'sh0000,
    16'sd12345,
    -16'sd5, 16'sd100, -16'sd32767,
    16'sd1000, -16'sd2000, 16'sd3000, 16'sh7FFF, 16'sh8000,
    16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001
  };
  localparam logic [24:0] DIRECTED_ENDS =
      (25'd1 << 9) | (25'd1 << 10) | (25'd1 << 13) | (25'd1 << 18) | (25'd1 << 24);

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  sample;
  logic                        end_of_record;
  logic                        out_valid;
  logic                        out_stall;
  logic [IDX_OUT_W-1:0]        point_index;
  logic signed [DER_W-1:0]     derivative;
  logic                        final_res;
  logic signed [DER_W-1:0]     peak_derivative;
  logic [STATUS_W-1:0]         status;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]            cfg_data;

  int mismatches;
  int outstanding;
  bit hold_request;
  bit tx_calm;

  always #2 clk_i = ~clk_i;

  smoothed_first_derivative_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .sample_i          (sample),
    .end_of_record_i   (end_of_record),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .point_index_o     (point_index),
    .derivative_o      (derivative),
    .final_res_o       (final_res),
    .peak_derivative_o (peak_derivative),
    .status_o          (status),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  sfd_slope_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .sample_i          (sample),
    .end_of_record_i   (end_of_record),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .point_index_i     (point_index),
    .derivative_i      (derivative),
    .final_res_i       (final_res),
    .peak_derivative_i (peak_derivative),
    .status_i          (status),
    .mismatch_count_o  (mismatches),
    .outstanding_o     (outstanding)
  );

  // Safety net against a hung core.
  initial begin
    #40_000_000;
    $display("** smoothed_first_derivative_core: FAILED **");
    $finish;
  end

  // Result side: mostly short stalls, a few long ones, calm stretches, and one long hold-off.
  initial begin : result_flow
    int len;
    int r;
    bit stall_now;
    bit calm;
    out_stall = 1'b0;
    calm = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_now = 1'b1;
        len = HOLD_CYCLES;
      end else if (calm || r < 60) begin
        stall_now = 1'b0;
        len = 1;
      end else if (r < 95) begin
        stall_now = 1'b1;
        len = $urandom_range(1, 4);
      end else begin
        stall_now = 1'b1;
        len = $urandom_range(20, 120);
      end
      out_stall <= stall_now;
      repeat (len - 1) @(negedge clk_i);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Offers one sample after a random gap and waits for its transfer.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x, input logic last);
    int gap;
    int r;
    gap = 0;
    if (!tx_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 55) gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 80);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    sample        <= x;
    end_of_record <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Stops offering and waits until every owed point has come back and the core is quiet.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Either full-range noise or a noisy ramp, so that both saturation and fine values occur.
  task automatic send_record(input int len, input bit smooth);
    int base;
    int slope;
    int val;
    int i;
    base  = int'($urandom_range(0, 40000)) - 20000;
    slope = int'($urandom_range(0, 600)) - 300;
    for (i = 0; i < len; i++) begin
      if (smooth) begin
        val = base + slope * i + int'($urandom_range(0, 100)) - 50;
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
      end else begin
        val = int'($urandom_range(0, 65535));
      end
      push_sample(SAMPLE_W'(val), i == len - 1);
    end
  endtask

  // One register setting, then random records until the phase has its share of samples.
  task automatic random_phase(input logic [ORDER_W-1:0] order, input logic [INV_W-1:0] inv,
                              input logic [LIMIT_W-1:0] limit, input bit squeeze);
    int sent;
    int len;
    int n;
    int pick;
    drain();
    write_reg(REG_ORDER, CFG_W'(order));
    write_reg(REG_INV, CFG_W'(inv));
    write_reg(REG_LIMIT, CFG_W'(limit));
    if (squeeze) hold_request = 1'b1;
    n = (order == 0) ? 1 : int'(order);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) len = $urandom_range(1, 3);
      else if (pick < 3) len = $urandom_range(2 * n - 1, 2 * n + 2);
      else len = $urandom_range(4, 28);
      send_record(len, $urandom_range(0, 1));
      sent += len;
    end
  endtask

  initial begin : stimulus
    int i;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    sample        = '0;
    end_of_record = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_ORDER;
    cfg_data      = '0;
    hold_request  = 1'b0;
    tx_calm       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed records: reset settings, then order zero with the most negative step and a
    // zero limit, then the widest order with the largest step and a limit of one.
    for (i = 0; i < 25; i++) begin
      if (i == 14) begin
        drain();
        write_reg(REG_ORDER, CFG_W'(0));
        write_reg(REG_INV, 24'h800000);
        write_reg(REG_LIMIT, CFG_W'(0));
      end
      if (i == 19) begin
        drain();
        write_reg(REG_ORDER, CFG_W'(15));
        write_reg(REG_INV, 24'h7FFFFF);
        write_reg(REG_LIMIT, CFG_W'(1));
      end
      push_sample(DIRECTED_SAMPLES[i], DIRECTED_ENDS[i]);
    end

    // Random phases over a spread of settings; the first one holds the results back for long.
    random_phase(4'd15, INV_W'($urandom_range(0, 24'h03FFFF)), 16'h8000, 1'b1);
    random_phase(4'd4, 24'h800000, 16'd1, 1'b0);
    random_phase(4'd7, 24'd0, 16'h8000, 1'b0);
    random_phase(4'd3, INV_W'($urandom), 16'd0, 1'b0);
    random_phase(ORDER_W'($urandom_range(0, 15)), INV_W'($urandom),
                 LIMIT_W'($urandom_range(1, 32768)), 1'b0);
    random_phase(4'd2, 24'd65536, 16'hFFFF, 1'b0);

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("** smoothed_first_derivative_core: PASSED **");
    end else begin
      $display("** smoothed_first_derivative_core: FAILED **");
    end
    $finish;
  end

endmodule
